@@ design/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

@@ design/tvms_pkg.sv @@
// package for the typed value memory scanner
// holds type codes, compare codes, config register indices, cell bus type and size helper; no dependencies
package tvms_pkg;
  localparam int unsigned WinBytes = 8;

  typedef enum logic [3:0] {
    TY_U8 = 4'd0, TY_I8 = 4'd1, TY_U16 = 4'd2, TY_I16 = 4'd3, TY_U32 = 4'd4,
    TY_I32 = 4'd5, TY_U64 = 4'd6, TY_I64 = 4'd7, TY_F32 = 4'd8, TY_F64 = 4'd9
  } value_type_t;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  localparam logic [1:0] REG_TYPE = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;
  localparam logic [1:0] REG_ALIGN = 2'd3;

  // item handed from cell to cell
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
  } cell_bus_t;

  // value size in bytes minus one
  function automatic logic [2:0] size_m1(input logic [3:0] t);
    logic [2:0] r;
    begin
      if (t <= 4'd1) r = 3'd0;
      else if (t <= 4'd3) r = 3'd1;
      else if (t <= 4'd5 || t == 4'd8) r = 3'd3;
      else r = 3'd7;
      return r;
    end
  endfunction
endpackage

@@ design/tvms_cell.sv @@
// one byte cell of the window chain
// depends on tvms_pkg
module tvms_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  tvms_pkg::cell_bus_t din,
  output tvms_pkg::cell_bus_t dout
);
  import tvms_pkg::*;

  // byte moves one cell per accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end
endmodule

@@ design/tvms_compare.sv @@
// compares the assembled value against the target
// depends on tvms_pkg
module tvms_compare (
  input  logic [3:0]  val_type,
  input  logic [1:0]  compare_mode,
  input  logic [63:0] target_value,
  input  logic [63:0] value,
  output logic        hit
);
  import tvms_pkg::*;

  logic [63:0] v;
  logic [63:0] t;
  logic [2:0]  sm1;
  logic        lt;
  logic        gt;
  logic        eq;
  logic        nan_v;
  logic        nan_t;
  logic        zero_both;
  logic        sa;
  logic        sb;
  logic [62:0] ma;
  logic [62:0] mb;

  // align value and target to 64 bits, map sign for ordering
  always_comb begin
    sm1 = size_m1(val_type);
    v = value >> {(3'd7 - sm1), 3'b000};
    t = target_value;
    unique case (sm1)
      3'd0: t = {56'd0, target_value[7:0]};
      3'd1: t = {48'd0, target_value[15:0]};
      3'd3: t = {32'd0, target_value[31:0]};
      default: t = target_value;
    endcase
    lt = 1'b0; gt = 1'b0; eq = 1'b0;
    nan_v = 1'b0; nan_t = 1'b0; zero_both = 1'b0;
    sa = 1'b0; sb = 1'b0; ma = '0; mb = '0;
    if (val_type == TY_F32 || val_type == TY_F64) begin
      if (val_type == TY_F32) begin
        sa = v[31]; sb = t[31];
        ma = {32'd0, v[30:0]}; mb = {32'd0, t[30:0]};
        nan_v = (v[30:23] == 8'hff) && (v[22:0] != '0);
        nan_t = (t[30:23] == 8'hff) && (t[22:0] != '0);
      end else begin
        sa = v[63]; sb = t[63];
        ma = v[62:0]; mb = t[62:0];
        nan_v = (v[62:52] == 11'h7ff) && (v[51:0] != '0);
        nan_t = (t[62:52] == 11'h7ff) && (t[51:0] != '0);
      end
      zero_both = (ma == '0) && (mb == '0);
      if (nan_v || nan_t) begin
        // unordered
      end else if (zero_both || (sa == sb && ma == mb)) begin
        eq = 1'b1;
      end else if (sa != sb) begin
        lt = sa; gt = sb;
      end else begin
        lt = sa ? (ma > mb) : (ma < mb);
        gt = !lt;
      end
    end else begin
      if (val_type[0]) begin
        v[{sm1, 3'b111}] = ~v[{sm1, 3'b111}];
        t[{sm1, 3'b111}] = ~t[{sm1, 3'b111}];
      end
      lt = v < t; gt = v > t; eq = v == t;
    end
    hit = 1'b0;
    if (val_type <= TY_F64) begin
      unique case (compare_mode)
        CMP_EQ:  hit = eq;
        CMP_GT:  hit = gt;
        CMP_LT:  hit = lt;
        default: hit = 1'b0;
      endcase
    end
  end
endmodule

@@ design/typed_value_memory_scan_top.sv @@
// top level of the typed value memory scanner
// depends on tvms_pkg, tvms_cell, tvms_compare
//
// usage:
//   s_axis carries one memory byte per transfer; tdata holds data_byte,
//   byte_address, span_start from bit 0 up. m_axis carries match_address.
//   config port: cfg_we, cfg_index (0 type, 1 mode, 2 target, 3 aligned),
//   cfg_data; write only while idle.
//   the last seven bytes sit in a chain of byte cells; each accepted byte
//   shifts the chain one cell. the new byte plus the chain feed one compare.
//   a match is registered in the output register and appears on m_axis in the cycle after the byte transfer.
//   throughput: one byte per cycle, set by the single compare stage and the
//   one-entry output register; the input stalls only while a result waits
//   and the output is stalled.
//   reset clears config, window, fill and offset; a stream without a span
//   start continues a span at offset zero.
//   a stalled receiver holds the result; s_axis_tready drops only while the
//   output register is full and not taken.
module typed_value_memory_scan_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // data_byte[7:0], byte_address[71:8], span_start[72]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // match_address[63:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import tvms_pkg::*;

  logic [3:0]  val_type;
  logic [1:0]  compare_mode;
  logic [63:0] target_value;
  logic        aligned_scan;
  logic [2:0]  span_fill;
  logic [2:0]  span_offset;
  logic        acc;
  logic [7:0]  in_byte;
  logic [63:0] in_addr;
  logic        in_first;
  logic [2:0]  fill;
  logic [2:0]  offset;
  logic [2:0]  sm1;
  logic [2:0]  start_off;
  logic [63:0] combined;
  logic        hit;
  logic        ok;
  cell_bus_t   chain [WinBytes];

  assign in_byte  = s_axis_tdata[7:0];
  assign in_addr  = s_axis_tdata[71:8];
  assign in_first = s_axis_tdata[72];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      val_type <= '0; compare_mode <= '0; target_value <= '0; aligned_scan <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TYPE:   val_type <= cfg_data[3:0];
        REG_MODE:   compare_mode <= cfg_data[1:0];
        REG_TARGET: target_value <= cfg_data;
        REG_ALIGN:  aligned_scan <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // window chain: slot 0 is the incoming byte itself, the cells hold the earlier bytes
  assign chain[0] = '{data: in_byte, first: in_first};
  for (genvar i = 1; i < WinBytes; i++) begin : g_cell
    tvms_cell u_cell (.clk(clk), .rst(rst), .shift(acc), .din(chain[i-1]), .dout(chain[i]));
  end

  always_comb begin
    combined[63:56] = in_byte;
    for (int i = 1; i < WinBytes; i++) combined[63-8*i -: 8] = chain[i].data;
  end

  tvms_compare u_cmp (
    .val_type(val_type), .compare_mode(compare_mode), .target_value(target_value),
    .value(combined), .hit(hit)
  );

  // span position and match qualification
  always_comb begin
    fill = in_first ? 3'd0 : span_fill;
    offset = in_first ? 3'd0 : span_offset;
    sm1 = size_m1(val_type);
    start_off = offset - sm1;
    ok = hit && (fill >= sm1) && !(aligned_scan && ((start_off & sm1) != 3'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_fill <= '0; span_offset <= '0;
    end else if (acc) begin
      span_fill <= (fill < 3'd7) ? fill + 3'd1 : 3'd7;
      span_offset <= offset + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= acc && ok;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && ok) m_axis_tdata <= in_addr - {61'd0, sm1};
  end
endmodule

@@ design/tvms_checker.sv @@
// port checker for the typed value memory scanner, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module tvms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CHK_IMPL(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
  `CHK_NEXT(a_cause, clk, rst, !(s_axis_tvalid && s_axis_tready) && !m_axis_tvalid, !m_axis_tvalid)
endmodule

bind typed_value_memory_scan_top tvms_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
